@@ src/grc_pkg.sv @@
`default_nettype none
package grc_pkg;

   // Divider sizes: the delta numerator is (3 * width) << 30.
   localparam int DIV_NUM_W = 44;
   localparam int DIV_DEN_W = 45;
   // The fraction multiplier can be 2^16, so it takes 17 bits.
   localparam int FRAC_MUL_STEPS = 17;

   localparam logic [63:0] RAY_INF  = 64'h4000_0000_0000_0000;
   localparam logic [12:0] LINE_MAX = 13'd8191;
   localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;

   // Configuration register indexes.
   localparam logic [2:0] CSR_EYE_X  = 3'd0;
   localparam logic [2:0] CSR_EYE_Y  = 3'd1;
   localparam logic [2:0] CSR_DIR_X  = 3'd2;
   localparam logic [2:0] CSR_DIR_Y  = 3'd3;
   localparam logic [2:0] CSR_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_HEIGHT = 3'd5;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PROD, S_RAY, S_DIV_X, S_MUL_X,
      S_DIV_Y, S_MUL_Y, S_WALK, S_DIV_LINE, S_OUT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_CLEAR, OP_NONE, OP_PROD, OP_RAY, OP_DIV_X, OP_MUL_X,
      OP_DIV_Y, OP_MUL_Y, OP_WALK, OP_DIV_LINE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      first;
      logic      map_wr;
      logic      capture;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic walk_end;
      logic clear_done;
   } dp_status_type;

   typedef struct packed {
      logic [21:0]        eye_x;
      logic [21:0]        eye_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [11:0]        width;
      logic [11:0]        height;
   } cfg_type;

endpackage
`default_nettype wire

@@ src/grid_dda_column_raycaster.sv @@
// Channel | Ports                                  | Handshake
// request | req_cmd, req_column_index, req_cell_*  | beat taken when start && !busy
// result  | rsp_out_column .. rsp_slice_end        | rsp_valid for one cycle
// config  | csr_we, csr_index, csr_wdata           | written when csr_we is high
//
// A map write takes effect at its accepting edge and the block stays free.
// A cast runs two ray setup steps, three divides on one shared bit-serial divider,
// two multiplies, the grid walk until it sees its end, and a result state
// (the walk takes at most 4 * MAP_SIDE + 256 steps).
// After reset the map is cleared one cell per cycle, all MAP_SIDE^2 cells, busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module grid_dda_column_raycaster
   import grc_pkg::*;
#(
   parameter int MAP_SIDE_LOG2 = 6,
   parameter int WALL_SCALE    = 400
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic          req_cmd,
   input  wire logic [10:0]   req_column_index,
   input  wire logic [5:0]    req_cell_x,
   input  wire logic [5:0]    req_cell_y,
   input  wire logic          req_cell_wall,
   output logic               rsp_valid,
   output logic [10:0]        rsp_out_column,
   output logic               rsp_wall_side,
   output logic [23:0]        rsp_wall_distance,
   output logic signed [12:0] rsp_slice_start,
   output logic [12:0]        rsp_slice_end,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [21:0]   csr_wdata
);

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eye_x  <= '0;
         cfg_ff.eye_y  <= '0;
         cfg_ff.dir_x  <= 16'sd16384;
         cfg_ff.dir_y  <= '0;
         cfg_ff.width  <= 12'd320;
         cfg_ff.height <= 12'd200;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EYE_X:  cfg_ff.eye_x  <= csr_wdata;
            CSR_EYE_Y:  cfg_ff.eye_y  <= csr_wdata;
            CSR_DIR_X:  cfg_ff.dir_x  <= $signed(csr_wdata[15:0]);
            CSR_DIR_Y:  cfg_ff.dir_y  <= $signed(csr_wdata[15:0]);
            CSR_WIDTH:  cfg_ff.width  <= csr_wdata[11:0];
            CSR_HEIGHT: cfg_ff.height <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   grc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   grc_datapath #(
      .MAP_SIDE_LOG2 (MAP_SIDE_LOG2),
      .WALL_SCALE    (WALL_SCALE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg_ff),
      .req_column_index  (req_column_index),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_cell_wall     (req_cell_wall),
      .status            (status),
      .rsp_out_column    (rsp_out_column),
      .rsp_wall_side     (rsp_wall_side),
      .rsp_wall_distance (rsp_wall_distance),
      .rsp_slice_start   (rsp_slice_start),
      .rsp_slice_end     (rsp_slice_end)
   );

   // A result beat only appears while a cast is in flight.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");

   // A result beat lasts exactly one cycle.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat held");

   // An accepted cast makes the block busy on the next cycle.
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd) |=> busy) else $error("cast not started");

   // A map write leaves the block free.
   a_wr_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_cmd) |=> !busy) else $error("map write blocked");

endmodule
`default_nettype wire

@@ src/grc_div.sv @@
`default_nettype none
module grc_div
   import grc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIV_DEN_W-1:0] den,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;

   // One restoring step: shift in the next numerator bit and subtract if it fits.
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      rem_in = rem_ff;
      quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_ff}) begin
         rem_in    = DIV_DEN_W'(trial - {1'b0, den_ff});
         quo_in[0] = 1'b1;
      end else begin
         rem_in = trial[DIV_DEN_W-1:0];
      end
   end

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_W'(DIV_NUM_W - 1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // Operand and partial result registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

@@ src/grc_datapath.sv @@
`default_nettype none
module grc_datapath
   import grc_pkg::*;
#(
   parameter int MAP_SIDE_LOG2 = 6,
   parameter int WALL_SCALE    = 400
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   input  wire cfg_type       cfg,
   input  wire logic [10:0]   req_column_index,
   input  wire logic [5:0]    req_cell_x,
   input  wire logic [5:0]    req_cell_y,
   input  wire logic          req_cell_wall,
   output dp_status_type      status,
   output logic [10:0]        rsp_out_column,
   output logic               rsp_wall_side,
   output logic [23:0]        rsp_wall_distance,
   output logic signed [12:0] rsp_slice_start,
   output logic [12:0]        rsp_slice_end
);

   localparam int L      = MAP_SIDE_LOG2;
   localparam int SIDE   = 1 << L;
   localparam int CELLS  = SIDE * SIDE;
   localparam int LIMIT  = 4 * SIDE + 256;
   localparam int CW     = (2 * L > $clog2(LIMIT + 1)) ? 2 * L : $clog2(LIMIT + 1);
   localparam int PW     = $clog2(LIMIT + 64) + 1;
   localparam int ACC_W  = FRAC_MUL_STEPS + DIV_NUM_W;
   localparam logic [DIV_NUM_W-1:0] LINE_NUM = DIV_NUM_W'(WALL_SCALE) << 16;

   // Wall map and iteration counter.
   logic           mem [CELLS];
   logic           rd_ff;
   logic           oob_ff;
   logic [CW-1:0]  cnt_ff;
   logic           we;
   logic [2*L-1:0] wa, ra;
   logic           wd;
   logic [L+5:0]   cx_w, cy_w;

   // Ray setup registers.
   logic signed [30:0] p1x_ff, p1y_ff;
   logic signed [28:0] p2x_ff, p2y_ff;
   logic signed [31:0] rx_ff, ry_ff;
   logic [13:0]        d_w;
   logic [11:0]        w_eff;
   logic signed [12:0] rel;

   // Walk registers.
   logic [63:0]          dx_ff, dy_ff, side_x_ff, side_y_ff;
   logic signed [PW-1:0] mx_ff, my_ff;
   logic                 side_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [16:0]          mpl_ff;

   // Divider connection.
   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den;

   logic [10:0] col_ff;
   logic [10:0] col_out_ff;
   logic        side_out_ff;
   logic [23:0] dist_ff;
   logic [12:0] start_ff, end_ff;

   logic        neg_x, neg_y, zero_x, zero_y;
   logic [31:0] mag_x, mag_y;
   logic [63:0] perp;
   logic        mul_x_op, mul_active;
   logic [43:0] mul_delta;
   logic        walk_step, hit_end;
   logic        take_x;
   logic signed [PW-1:0] cur_x, cur_y, nx, ny;
   logic [64:0] sum_x, sum_y;
   logic [12:0] lh;
   logic signed [13:0] diff, half;
   logic [13:0] hsum;

   // Screen geometry: zero width counts as one.
   always_comb begin
      w_eff = (cfg.width == 12'd0) ? 12'd1 : cfg.width;
      d_w   = 14'({w_eff, 1'b0}) + 14'(w_eff);
      rel   = $signed({1'b0, col_ff, 1'b0}) - $signed({1'b0, w_eff});
   end

   always_comb begin
      neg_x  = rx_ff[31];
      neg_y  = ry_ff[31];
      zero_x = (rx_ff == '0);
      zero_y = (ry_ff == '0);
      mag_x  = neg_x ? 32'(-rx_ff) : 32'(rx_ff);
      mag_y  = neg_y ? 32'(-ry_ff) : 32'(ry_ff);
      perp   = side_ff ? (side_y_ff - dy_ff) : (side_x_ff - dx_ff);
   end

   // Ray products, then the sums, one register after each.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff <= req_column_index;
      end
      if (cmd.op == OP_PROD) begin
         p1x_ff <= $signed({1'b0, d_w}) * cfg.dir_x;
         p1y_ff <= $signed({1'b0, d_w}) * cfg.dir_y;
         p2x_ff <= cfg.dir_y * rel;
         p2y_ff <= cfg.dir_x * rel;
      end
      if (cmd.op == OP_RAY) begin
         rx_ff <= 32'(p1x_ff) - (32'(p2x_ff) <<< 1);
         ry_ff <= 32'(p1y_ff) + (32'(p2y_ff) <<< 1);
      end
   end

   // Shared divider operands.
   always_comb begin
      div_start = cmd.first &&
                  (cmd.op == OP_DIV_X || cmd.op == OP_DIV_Y || cmd.op == OP_DIV_LINE);
      div_num   = DIV_NUM_W'(d_w) << 30;
      div_den   = DIV_DEN_W'(mag_x);
      if (cmd.op == OP_DIV_Y) begin
         div_den = DIV_DEN_W'(mag_y);
      end else if (cmd.op == OP_DIV_LINE) begin
         div_num = LINE_NUM;
         div_den = (perp[63:DIV_NUM_W] != '0) ? {1'b1, {DIV_NUM_W{1'b0}}}
                                              : DIV_DEN_W'(perp);
      end
   end

   grc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Fraction multiply, most significant bit first.
   always_comb begin
      mul_x_op   = (cmd.op == OP_MUL_X);
      mul_active = (cmd.op == OP_MUL_X || cmd.op == OP_MUL_Y);
      mul_delta  = mul_x_op ? dx_ff[43:0] : dy_ff[43:0];
   end

   // Walk step: choose the axis, move one cell, look up the cell entered.
   always_comb begin
      take_x  = side_x_ff < side_y_ff;
      cur_x   = cmd.first ? PW'(cfg.eye_x[21:16]) : mx_ff;
      cur_y   = cmd.first ? PW'(cfg.eye_y[21:16]) : my_ff;
      nx      = cur_x;
      ny      = cur_y;
      if (take_x) begin
         nx = cur_x + (neg_x ? {PW{1'b1}} : PW'(1));
      end else begin
         ny = cur_y + (neg_y ? {PW{1'b1}} : PW'(1));
      end
      sum_x   = {1'b0, side_x_ff} + {1'b0, dx_ff};
      sum_y   = {1'b0, side_y_ff} + {1'b0, dy_ff};
      hit_end = rd_ff || oob_ff || (cnt_ff == CW'(LIMIT));
      walk_step = (cmd.op == OP_WALK) && (cmd.first || !hit_end);
      ra      = {ny[L-1:0], nx[L-1:0]};
   end

   // Map writes and the clearing sweep share the write port.
   always_comb begin
      cx_w = {{L{1'b0}}, req_cell_x};
      cy_w = {{L{1'b0}}, req_cell_y};
      we   = 1'b0;
      wa   = cnt_ff[2*L-1:0];
      wd   = 1'b0;
      if (cmd.op == OP_CLEAR) begin
         we = 1'b1;
      end else if (cmd.map_wr && cx_w < (L+6)'(SIDE) && cy_w < (L+6)'(SIDE)) begin
         we = 1'b1;
         wa = {cy_w[L-1:0], cx_w[L-1:0]};
         wd = req_cell_wall;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   // Counter shared by the clearing sweep, the multiplies and the walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.op == OP_CLEAR) begin
         cnt_ff <= cnt_ff + 1'b1;
      end else if (cmd.first) begin
         cnt_ff <= (cmd.op == OP_WALK) ? CW'(1) : '0;
      end else if (walk_step || (mul_active && cnt_ff != CW'(FRAC_MUL_STEPS))) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Deltas, first borders and the walk itself.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIV_X && div_done) begin
         dx_ff <= zero_x ? RAY_INF : 64'(div_quo);
      end
      if (cmd.op == OP_DIV_Y && div_done) begin
         dy_ff <= zero_y ? RAY_INF : 64'(div_quo);
      end
      if (mul_active && cmd.first) begin
         acc_ff <= '0;
         if (mul_x_op) begin
            mpl_ff <= neg_x ? {1'b0, cfg.eye_x[15:0]} : 17'h10000 - 17'(cfg.eye_x[15:0]);
         end else begin
            mpl_ff <= neg_y ? {1'b0, cfg.eye_y[15:0]} : 17'h10000 - 17'(cfg.eye_y[15:0]);
         end
      end else if (mul_active && cnt_ff != CW'(FRAC_MUL_STEPS)) begin
         acc_ff <= (acc_ff << 1) + (mpl_ff[16] ? ACC_W'(mul_delta) : '0);
         mpl_ff <= mpl_ff << 1;
      end
      if (cmd.op == OP_MUL_X && !cmd.first && cnt_ff == CW'(FRAC_MUL_STEPS)) begin
         side_x_ff <= zero_x ? RAY_INF : 64'(acc_ff[ACC_W-1:16]);
      end else if (walk_step && take_x) begin
         side_x_ff <= sum_x[64] ? '1 : sum_x[63:0];
      end
      if (cmd.op == OP_MUL_Y && !cmd.first && cnt_ff == CW'(FRAC_MUL_STEPS)) begin
         side_y_ff <= zero_y ? RAY_INF : 64'(acc_ff[ACC_W-1:16]);
      end else if (walk_step && !take_x) begin
         side_y_ff <= sum_y[64] ? '1 : sum_y[63:0];
      end
      if (walk_step) begin
         mx_ff   <= nx;
         my_ff   <= ny;
         side_ff <= !take_x;
         oob_ff  <= nx[PW-1] || (nx[PW-2:L] != '0) || ny[PW-1] || (ny[PW-2:L] != '0);
      end
   end

   // Line height and slice rows from the final quotient.
   always_comb begin
      if (perp == '0 || div_quo > DIV_NUM_W'(LINE_MAX)) begin
         lh = LINE_MAX;
      end else begin
         lh = div_quo[12:0];
      end
      diff = $signed({2'b0, cfg.height}) - $signed({1'b0, lh});
      half = (diff + 14'(diff[13])) >>> 1;
      hsum = 14'(cfg.height) + 14'(lh);
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIV_LINE && div_done) begin
         col_out_ff  <= col_ff;
         side_out_ff <= side_ff;
         dist_ff     <= (perp > 64'(DIST_MAX)) ? DIST_MAX : perp[23:0];
         start_ff    <= half[12:0];
         end_ff      <= hsum[13:1];
      end
   end

   always_comb begin
      status.div_done   = div_done;
      status.mul_done   = mul_active && !cmd.first && (cnt_ff == CW'(FRAC_MUL_STEPS));
      status.walk_end   = (cmd.op == OP_WALK) && !cmd.first && hit_end;
      status.clear_done = (cmd.op == OP_CLEAR) && (cnt_ff == CW'(CELLS - 1));
   end

   assign rsp_out_column    = col_out_ff;
   assign rsp_wall_side     = side_out_ff;
   assign rsp_wall_distance = dist_ff;
   assign rsp_slice_start   = $signed(start_ff);
   assign rsp_slice_end     = end_ff;

endmodule
`default_nettype wire

@@ src/grc_ctrl.sv @@
`default_nettype none
module grc_ctrl
   import grc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_cmd,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd,
   output logic               busy,
   output logic               rsp_valid
);

   ctrl_state_type state_ff, state_in;
   logic           first_ff;
   logic           accept;

   assign accept = start && (state_ff == S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:    if (status.clear_done) state_in = S_IDLE;
         S_IDLE:     if (accept && req_cmd) state_in = S_PROD;
         S_PROD:     state_in = S_RAY;
         S_RAY:      state_in = S_DIV_X;
         S_DIV_X:    if (status.div_done) state_in = S_MUL_X;
         S_MUL_X:    if (status.mul_done) state_in = S_DIV_Y;
         S_DIV_Y:    if (status.div_done) state_in = S_MUL_Y;
         S_MUL_Y:    if (status.mul_done) state_in = S_WALK;
         S_WALK:     if (status.walk_end) state_in = S_DIV_LINE;
         S_DIV_LINE: if (status.div_done) state_in = S_OUT;
         S_OUT:      state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         first_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         first_ff <= (state_in != state_ff);
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd.first   = first_ff;
      cmd.map_wr  = accept && !req_cmd;
      cmd.capture = accept && req_cmd;
      busy        = (state_ff != S_IDLE);
      rsp_valid   = (state_ff == S_OUT);
      unique case (state_ff)
         S_CLEAR:    cmd.op = OP_CLEAR;
         S_PROD:     cmd.op = OP_PROD;
         S_RAY:      cmd.op = OP_RAY;
         S_DIV_X:    cmd.op = OP_DIV_X;
         S_MUL_X:    cmd.op = OP_MUL_X;
         S_DIV_Y:    cmd.op = OP_DIV_Y;
         S_MUL_Y:    cmd.op = OP_MUL_Y;
         S_WALK:     cmd.op = OP_WALK;
         S_DIV_LINE: cmd.op = OP_DIV_LINE;
         default:    cmd.op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire
